FILE: sv/rtyp_pkg.sv
`timescale 1ns / 1ps
package rtyp_pkg;
  localparam int DATA_WIDTH = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD = 32 - DATA_WIDTH;
  localparam int VW = 36;
  localparam int STG_W = 5;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic signed [30:0] INVK_Q30 = 31'sd652032874;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
  } vec_t;

  typedef struct packed {
    logic        valid;
    logic        zero;
    vec_t        v;
    logic [31:0] z;
  } lane_t;

  function automatic logic [31:0] atan_lut(input logic [STG_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction
endpackage

FILE: sv/rotation_to_yaw_pitch_roll.sv
`timescale 1ns / 1ps
// Path to out_valid: u_ypre, g_yaw cells, mv_r, u_ppre/u_rpre, g_pr cells, out regs.
// Throughput: one request per cycle, set by the fully pipelined CORDIC cell chains.
// busy is high only while rst_n is low; the receiver cannot stall.
// Reset (synchronous, active low) clears all pipeline valid bits; no results follow.
module rotation_to_yaw_pitch_roll (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rtyp_pkg::DATA_WIDTH-1:0] in_m00,
  input  logic signed [rtyp_pkg::DATA_WIDTH-1:0] in_m10,
  input  logic signed [rtyp_pkg::DATA_WIDTH-1:0] in_m20,
  input  logic signed [rtyp_pkg::DATA_WIDTH-1:0] in_m01,
  input  logic signed [rtyp_pkg::DATA_WIDTH-1:0] in_m11,
  input  logic signed [rtyp_pkg::DATA_WIDTH-1:0] in_m02,
  input  logic signed [rtyp_pkg::DATA_WIDTH-1:0] in_m12,
  output logic                                out_valid,
  output logic signed [rtyp_pkg::DATA_WIDTH-1:0] out_yaw_angle,
  output logic signed [rtyp_pkg::DATA_WIDTH-1:0] out_pitch_angle,
  output logic signed [rtyp_pkg::DATA_WIDTH-1:0] out_roll_angle
);
  import rtyp_pkg::*;

  localparam int PROD_W = VW + 31;

  function automatic logic signed [VW-1:0] widen(input logic signed [DATA_WIDTH-1:0] a);
    logic signed [VW-1:0] e;
    e = VW'(a);
    return e <<< GUARD;
  endfunction

  logic  accept;
  vec_t  in_n, in_o, in_a;
  lane_t yl [0:CORDIC_STAGES];
  vec_t  yo [0:CORDIC_STAGES];
  vec_t  ya [0:CORDIC_STAGES];
  lane_t pl [0:CORDIC_STAGES];
  vec_t  pc1 [0:CORDIC_STAGES];
  vec_t  pc2 [0:CORDIC_STAGES];
  lane_t rl [0:CORDIC_STAGES];
  vec_t  rc1 [0:CORDIC_STAGES];
  vec_t  rc2 [0:CORDIC_STAGES];

  logic                  mv_r;
  logic signed [VW-1:0]  h_r, m20n_r, rx_r, ry_r;
  logic signed [VW-1:0]  m20n_d_r [0:CORDIC_STAGES];
  logic [31:0]           yaw_d_r [0:CORDIC_STAGES+1];
  logic signed [PROD_W-1:0] prod;
  vec_t                  pv, rv;
  logic [31:0]           ys, ps, rs;

  assign busy = !rst_n;
  assign accept = start && !busy;

  always_comb begin
    in_n.x = widen(in_m00);
    in_n.y = widen(in_m10);
    in_o.x = widen(in_m01);
    in_o.y = widen(in_m11);
    in_a.x = widen(in_m02);
    in_a.y = widen(in_m12);
  end

  rtyp_prerot u_ypre (
    .clk(clk), .rst_n(rst_n), .in_valid(accept),
    .in_v(in_n), .in_c1(in_o), .in_c2(in_a),
    .out_l(yl[0]), .out_c1(yo[0]), .out_c2(ya[0])
  );

  // hold -m20 beside the yaw chain
  always_ff @(posedge clk) begin
    m20n_d_r[0] <= -widen(in_m20);
    for (int k = 1; k <= CORDIC_STAGES; k++) begin
      m20n_d_r[k] <= m20n_d_r[k-1];
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_yaw
    rtyp_cell u_cell (
      .clk(clk), .rst_n(rst_n), .stage_idx(STG_W'(i)),
      .in_l(yl[i]), .in_c1(yo[i]), .in_c2(ya[i]),
      .out_l(yl[i+1]), .out_c1(yo[i+1]), .out_c2(ya[i+1])
    );
  end

  assign prod = PROD_W'(yl[CORDIC_STAGES].v.x) * PROD_W'(INVK_Q30)
              + (PROD_W'(1) <<< 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else begin
      mv_r <= yl[CORDIC_STAGES].valid;
    end
    h_r <= prod[VW+29:30];
    m20n_r <= m20n_d_r[CORDIC_STAGES];
    rx_r <= yo[CORDIC_STAGES].y;
    ry_r <= -ya[CORDIC_STAGES].y;
  end

  always_ff @(posedge clk) begin
    yaw_d_r[0] <= yl[CORDIC_STAGES].z;
    for (int k = 1; k <= CORDIC_STAGES + 1; k++) begin
      yaw_d_r[k] <= yaw_d_r[k-1];
    end
  end

  always_comb begin
    pv.x = h_r;
    pv.y = m20n_r;
    rv.x = rx_r;
    rv.y = ry_r;
  end

  rtyp_prerot u_ppre (
    .clk(clk), .rst_n(rst_n), .in_valid(mv_r),
    .in_v(pv), .in_c1('0), .in_c2('0),
    .out_l(pl[0]), .out_c1(pc1[0]), .out_c2(pc2[0])
  );

  rtyp_prerot u_rpre (
    .clk(clk), .rst_n(rst_n), .in_valid(mv_r),
    .in_v(rv), .in_c1('0), .in_c2('0),
    .out_l(rl[0]), .out_c1(rc1[0]), .out_c2(rc2[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pr
    rtyp_cell u_pcell (
      .clk(clk), .rst_n(rst_n), .stage_idx(STG_W'(i)),
      .in_l(pl[i]), .in_c1(pc1[i]), .in_c2(pc2[i]),
      .out_l(pl[i+1]), .out_c1(pc1[i+1]), .out_c2(pc2[i+1])
    );
    rtyp_cell u_rcell (
      .clk(clk), .rst_n(rst_n), .stage_idx(STG_W'(i)),
      .in_l(rl[i]), .in_c1(rc1[i]), .in_c2(rc2[i]),
      .out_l(rl[i+1]), .out_c1(rc1[i+1]), .out_c2(rc2[i+1])
    );
  end

  always_comb begin
    ys = yaw_d_r[CORDIC_STAGES+1] + (32'h1 << (GUARD - 1));
    ps = pl[CORDIC_STAGES].z + (32'h1 << (GUARD - 1));
    rs = rl[CORDIC_STAGES].z + (32'h1 << (GUARD - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pl[CORDIC_STAGES].valid;
    end
    out_yaw_angle <= ys[31:GUARD];
    out_pitch_angle <= ps[31:GUARD];
    out_roll_angle <= rs[31:GUARD];
  end
endmodule

FILE: sv/rtyp_prerot.sv
`timescale 1ns / 1ps
module rtyp_prerot (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  rtyp_pkg::vec_t in_v,
  input  rtyp_pkg::vec_t in_c1,
  input  rtyp_pkg::vec_t in_c2,
  output rtyp_pkg::lane_t out_l,
  output rtyp_pkg::vec_t out_c1,
  output rtyp_pkg::vec_t out_c2
);
  import rtyp_pkg::*;

  logic  zero, neg, up;
  lane_t l_nxt;
  vec_t  c1_nxt, c2_nxt;

  function automatic vec_t turn(input vec_t a, input logic u);
    vec_t r;
    if (u) begin
      r.x = a.y;
      r.y = -a.x;
    end else begin
      r.x = -a.y;
      r.y = a.x;
    end
    return r;
  endfunction

  always_comb begin
    zero = (in_v.x == '0) && (in_v.y == '0);
    neg = in_v.x < 0;
    up = in_v.y >= 0;
    l_nxt.valid = in_valid;
    l_nxt.zero = zero;
    l_nxt.v = in_v;
    l_nxt.z = '0;
    c1_nxt = in_c1;
    c2_nxt = in_c2;
    if (!zero && neg) begin
      l_nxt.v = turn(in_v, up);
      c1_nxt = turn(in_c1, up);
      c2_nxt = turn(in_c2, up);
      l_nxt.z = up ? QUARTER_TURN : (32'h0 - QUARTER_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_l.valid <= 1'b0;
    end else begin
      out_l.valid <= l_nxt.valid;
    end
    out_l.zero <= l_nxt.zero;
    out_l.v <= l_nxt.v;
    out_l.z <= l_nxt.z;
    out_c1 <= c1_nxt;
    out_c2 <= c2_nxt;
  end
endmodule

FILE: sv/rtyp_cell.sv
`timescale 1ns / 1ps
module rtyp_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rtyp_pkg::STG_W-1:0] stage_idx,
  input  rtyp_pkg::lane_t           in_l,
  input  rtyp_pkg::vec_t            in_c1,
  input  rtyp_pkg::vec_t            in_c2,
  output rtyp_pkg::lane_t           out_l,
  output rtyp_pkg::vec_t            out_c1,
  output rtyp_pkg::vec_t            out_c2
);
  import rtyp_pkg::*;

  logic  up;
  lane_t l_nxt;
  vec_t  c1_nxt, c2_nxt;

  function automatic vec_t micro(input vec_t a, input logic u, input logic [STG_W-1:0] s);
    vec_t r;
    logic signed [VW-1:0] dx, dy;
    dx = a.y >>> s;
    dy = a.x >>> s;
    if (u) begin
      r.x = a.x + dx;
      r.y = a.y - dy;
    end else begin
      r.x = a.x - dx;
      r.y = a.y + dy;
    end
    return r;
  endfunction

  always_comb begin
    up = in_l.v.y >= 0;
    l_nxt = in_l;
    c1_nxt = in_c1;
    c2_nxt = in_c2;
    if (!in_l.zero) begin
      l_nxt.v = micro(in_l.v, up, stage_idx);
      c1_nxt = micro(in_c1, up, stage_idx);
      c2_nxt = micro(in_c2, up, stage_idx);
      l_nxt.z = up ? (in_l.z + atan_lut(stage_idx)) : (in_l.z - atan_lut(stage_idx));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_l.valid <= 1'b0;
    end else begin
      out_l.valid <= l_nxt.valid;
    end
    out_l.zero <= l_nxt.zero;
    out_l.v <= l_nxt.v;
    out_l.z <= l_nxt.z;
    out_c1 <= c1_nxt;
    out_c2 <= c2_nxt;
  end
endmodule

FILE: sv/rtyp_checker.sv
`timescale 1ns / 1ps
module rtyp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import rtyp_pkg::*;

  localparam int LAT = 2 * CORDIC_STAGES + 4;

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request produced no result");

  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without request");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy outside reset");
endmodule

bind rotation_to_yaw_pitch_roll rtyp_checker u_rtyp_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rtyp_pkg::*;

  localparam int LAT = 2 * CORDIC_STAGES + 4;
  localparam int WD_LIMIT = 2000;
  localparam logic signed [63:0] INVK = 64'sd652032874;

  typedef logic signed [DATA_WIDTH-1:0] ent_t;

  typedef struct packed {
    ent_t yaw;
    ent_t pitch;
    ent_t roll;
  } euler_t;

  typedef struct {
    logic signed [63:0] x;
    logic signed [63:0] y;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ent_t in_m00 = '0, in_m10 = '0, in_m20 = '0, in_m01 = '0;
  ent_t in_m11 = '0, in_m02 = '0, in_m12 = '0;
  logic out_valid;
  ent_t out_yaw_angle, out_pitch_angle, out_roll_angle;

  euler_t angles_due[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  rotation_to_yaw_pitch_roll dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_m00(in_m00), .in_m10(in_m10), .in_m20(in_m20), .in_m01(in_m01),
    .in_m11(in_m11), .in_m02(in_m02), .in_m12(in_m12),
    .out_valid(out_valid), .out_yaw_angle(out_yaw_angle),
    .out_pitch_angle(out_pitch_angle), .out_roll_angle(out_roll_angle)
  );

  always #4 clk = ~clk;

  function automatic logic signed [63:0] widen(ent_t e);
    return 64'(e) <<< GUARD;
  endfunction

  function automatic logic [31:0] vectoring(ref pair_t v[3], input int n);
    logic [31:0] z;
    logic signed [63:0] x, y;
    bit up;
    z = '0;
    if (v[0].x == 0 && v[0].y == 0) return z;
    if (v[0].x < 0) begin
      up = (v[0].y >= 0);
      z = up ? QUARTER_TURN : -QUARTER_TURN;
      for (int k = 0; k < n; k++) begin
        x = v[k].x;
        y = v[k].y;
        v[k].x = up ? y : -y;
        v[k].y = up ? -x : x;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 30; i++) begin
      up = (v[0].y >= 0);
      for (int k = 0; k < n; k++) begin
        x = v[k].x;
        y = v[k].y;
        v[k].x = up ? x + (y >>> i) : x - (y >>> i);
        v[k].y = up ? y - (x >>> i) : y + (x >>> i);
      end
      z = up ? z + atan_lut(i[STG_W-1:0]) : z - atan_lut(i[STG_W-1:0]);
    end
    return z;
  endfunction

  function automatic ent_t to_binang(logic [31:0] z);
    logic [31:0] r;
    r = z + (32'd1 << (GUARD - 1));
    return ent_t'(r >> GUARD);
  endfunction

  function automatic euler_t zyx_angles(ent_t m00, m10, m20, m01, m11, m02, m12);
    pair_t c[3];
    pair_t p[3];
    euler_t e;
    logic signed [63:0] h;
    c[0] = '{widen(m00), widen(m10)};
    c[1] = '{widen(m01), widen(m11)};
    c[2] = '{widen(m02), widen(m12)};
    e.yaw = to_binang(vectoring(c, 3));
    h = (c[0].x * INVK + (64'sd1 <<< 29)) >>> 30;
    p[0] = '{h, -widen(m20)};
    e.pitch = to_binang(vectoring(p, 1));
    p[0] = '{c[1].y, -c[2].y};
    e.roll = to_binang(vectoring(p, 1));
    return e;
  endfunction

  task automatic send_matrix(ent_t m00, m10, m20, m01, m11, m02, m12);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_m00 <= m00; in_m10 <= m10; in_m20 <= m20; in_m01 <= m01;
    in_m11 <= m11; in_m02 <= m02; in_m12 <= m12;
    @(posedge clk);
    while (busy) @(posedge clk);
    angles_due.push_back(zyx_angles(m00, m10, m20, m01, m11, m02, m12));
  endtask

  function automatic ent_t rand_entry();
    case ($urandom_range(0, 3))
      0: return ent_t'($urandom);
      1: return ent_t'($urandom_range(0, 32768) - 16384);
      2: return ent_t'($urandom_range(0, 64) - 32);
      default: return ent_t'($urandom_range(0, 1) ? 16384 : -16384);
    endcase
  endfunction

  task automatic test_directed();
    ent_t one, mn, mx;
    one = 16384;
    mn = -32768;
    mx = 32767;
    send_matrix(one, 0, 0, 0, one, 0, one);
    send_matrix(0, 0, 0, 0, 0, 0, 0);
    send_matrix(0, 0, -one, 0, one, one, 0);
    send_matrix(0, 0, one, one, 0, 0, one);
    send_matrix(0, 0, -one, 0, 0, 0, -one);
    send_matrix(-one, 0, 0, 0, -one, 0, one);
    send_matrix(-one, 0, 0, 0, one, 0, 0);
    send_matrix(0, one, 0, -one, 0, 0, one);
    send_matrix(0, -one, 0, one, 0, 0, one);
    send_matrix(11585, 11585, 0, -11585, 11585, 0, one);
    send_matrix(-11585, -11585, 11585, 8192, -8192, 8192, 8192);
    send_matrix(mn, mn, mn, mn, mn, mn, mn);
    send_matrix(mx, mx, mx, mx, mx, mx, mx);
    send_matrix(mn, mx, mn, mx, mn, mx, mn);
    send_matrix(mx, mn, mx, mn, mx, mn, mx);
    send_matrix(-1, 0, 0, 0, -1, 0, 0);
    send_matrix(-1, -1, 1, 1, -1, -1, 1);
    send_matrix(1, 1, -1, -1, 1, 1, -1);
    send_matrix(16384, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_rotations(int n);
    real y, p, r, cy, sy, cp, sp, cr, sr, s;
    s = 16384.0;
    for (int i = 0; i < n; i++) begin
      y = ($urandom_range(0, 65535) / 65536.0 - 0.5) * 6.2831853;
      p = ($urandom_range(0, 65535) / 65536.0 - 0.5) * 3.1415926;
      r = ($urandom_range(0, 65535) / 65536.0 - 0.5) * 6.2831853;
      cy = $cos(y); sy = $sin(y); cp = $cos(p); sp = $sin(p);
      cr = $cos(r); sr = $sin(r);
      send_matrix(ent_t'($rtoi(cy * cp * s)), ent_t'($rtoi(sy * cp * s)),
                  ent_t'($rtoi(-sp * s)),
                  ent_t'($rtoi((cy * sp * sr - sy * cr) * s)),
                  ent_t'($rtoi((sy * sp * sr + cy * cr) * s)),
                  ent_t'($rtoi((cy * sp * cr + sy * sr) * s)),
                  ent_t'($rtoi((sy * sp * cr - cy * sr) * s)));
    end
  endtask

  task automatic test_arbitrary(int n);
    for (int i = 0; i < n; i++)
      send_matrix(rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                  rand_entry(), rand_entry(), rand_entry());
  endtask

  task automatic test_back_to_back(int n);
    quiet = 1'b1;
    test_rotations(n / 2);
    test_arbitrary(n - n / 2);
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    euler_t want;
    if (rst_n && out_valid) begin
      if (angles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = angles_due.pop_front();
        if (out_yaw_angle !== want.yaw || out_pitch_angle !== want.pitch ||
            out_roll_angle !== want.roll) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected y=%0d p=%0d r=%0d got y=%0d p=%0d r=%0d",
                     want.yaw, want.pitch, want.roll,
                     out_yaw_angle, out_pitch_angle, out_roll_angle);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_rotations(350);
    test_arbitrary(200);
    test_back_to_back(150);
    start <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (LAT + 8) @(posedge clk);
    if (mismatches == 0 && angles_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
sv/rtyp_pkg.sv
sv/rtyp_prerot.sv
sv/rtyp_cell.sv
sv/rotation_to_yaw_pitch_roll.sv
sv/rtyp_checker.sv
bench/tb_top.sv
